// ===== sv/kkt_pkg.sv =====
// Shared types, constants and a helper function of the kernel threshold block.
package kkt_pkg;

  localparam int VAL_W       = 32;
  localparam int ROW_W       = 10;
  localparam int K_W         = 5;
  localparam int SEEN_W      = 11;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_AW      = 3;

  localparam int DEF_MAX_K    = 16;
  localparam int DEF_MAX_ROWS = 1024;

  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam logic [K_W-1:0]    K_RESET  = 5'd2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  localparam logic KIND_BAR    = 1'b0;
  localparam logic KIND_FILTER = 1'b1;

  localparam logic REG_K    = 1'b0;
  localparam logic REG_REPL = 1'b1;

  // Link between neighboring cells of the top-k chain.
  typedef struct packed {
    logic             keep;
    logic             vld;
    logic [VAL_W-1:0] val;
  } kkt_link_t;

  // Signed order on raw Q16.16 words.
  function automatic logic kkt_ge(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    return $signed(a) >= $signed(b);
  endfunction

endpackage

// ===== sv/kkt_cell.sv =====
// One cell of the sorted top-k chain: holds one value and its valid bit.
module kkt_cell
  import kkt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             ins,
  input  logic [VAL_W-1:0] din,
  input  kkt_link_t        prv,
  output kkt_link_t        lnk
);

  logic             vld_r, vld_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             keep;

  // A cell whose value is at least the new one keeps it; the first cell that
  // does not keep takes the new value, and every cell behind it shifts down.
  assign keep = vld_r && kkt_ge(val_r, din);

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (clr) begin
      vld_nxt = 1'b0;
    end else if (ins && !keep) begin
      if (prv.keep) begin
        val_nxt = din;
        vld_nxt = 1'b1;
      end else begin
        val_nxt = prv.val;
        vld_nxt = prv.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign lnk = '{keep: keep, vld: vld_r, val: val_r};

endmodule

// ===== sv/kkt_chain.sv =====
// Row of top-k cells kept in descending order, with the rank-k tap.
module kkt_chain
  import kkt_pkg::*;
#(
  parameter int MAX_K = DEF_MAX_K,
  parameter int KIW   = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             ins,
  input  logic [VAL_W-1:0] din,
  input  logic [KIW-1:0]   sel,
  output logic [VAL_W-1:0] bar_val
);

  kkt_link_t        lnk [MAX_K];
  kkt_link_t        prv [MAX_K];
  logic [MAX_K-1:0] vld_vec;

  always_comb begin
    prv[0] = '{keep: 1'b1, vld: 1'b1, val: din};
    for (int i = 1; i < MAX_K; i++) begin
      prv[i] = lnk[i-1];
    end
    for (int i = 0; i < MAX_K; i++) begin
      vld_vec[i] = lnk[i].vld;
    end
  end

  for (genvar g = 0; g < MAX_K; g++) begin : g_cell
    kkt_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .clr  (clr),
      .ins  (ins),
      .din  (din),
      .prv  (prv[g]),
      .lnk  (lnk[g])
    );
  end

  assign bar_val = lnk[sel].val;

  // Valid cells always form a prefix of the chain.
  a_vld_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_vec & (vld_vec + 1'b1)) == '0)
    else $error("top-k chain valid bits are not a prefix");

endmodule

// ===== sv/kkt_bar_ram.sv =====
// Per-row bar store: one write port, two registered read ports.
module kkt_bar_ram
  import kkt_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_ROWS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    ra_addr,
  input  logic [AW-1:0]    rb_addr,
  output logic [VAL_W-1:0] ra_data,
  output logic [VAL_W-1:0] rb_data
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      ra_data <= mem[ra_addr];
      rb_data <= mem[rb_addr];
    end
  end

endmodule

// ===== sv/knn_kernel_threshold.sv =====
// Top level of the k-nearest-neighbor kernel threshold block.
//
// Load transfers (tuser 0) stream one kernel row, one similarity per transfer,
// with tlast on the last entry. A chain of MAX_K cells keeps the largest values
// of the row in descending order, one insertion per cycle while in_tready is
// high. A row-ending load is followed by a bar state, which reads the k-th
// cell, writes it into the per-row bar memory and emits a bar result
// (short_row set and value zero when the row had fewer than k entries, in
// which case the stored bar is untouched). Filter transfers (tuser 1) are
// followed by a filter state that uses the registered dual read of the bar
// memory for the row and the column; the similarity passes when it is
// at least either bar, otherwise replacement_value is returned. A filter may
// only name rows that were loaded since reset; rows at or beyond MAX_ROWS have
// no bar. The bar memory needs no clearing pass, so the block takes transfers
// right after reset. A finished result waits in an output register; the next
// input transfer is taken once that register is free or being emptied. All
// values are signed Q16.16. neighbour_count of zero acts as one and values
// above MAX_K act as MAX_K.
module knn_kernel_threshold
  import kkt_pkg::*;
#(
  parameter int MAX_K    = DEF_MAX_K,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata, from bit 0: row_index[9:0], col_index[19:10], similarity[51:20], zero pad.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: opcode.
  input  logic                   in_tuser,
  // tlast: row_last.
  input  logic                   in_tlast,
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata, from bit 0: result_value[31:0], kept[32], short_row[33], zero pad.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // tuser: result_kind.
  output logic                   out_tuser,
  // Configuration port.
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KXW = ($clog2(MAX_K + 1) > K_W) ? $clog2(MAX_K + 1) : K_W;
  localparam int RWW = AW + ROW_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BAR    = 2'd1;
  localparam logic [1:0] ST_FILTER = 2'd2;

  // Configuration registers.
  logic [K_W-1:0]   cfg_k_r;
  logic [VAL_W-1:0] cfg_repl_r;
  logic             cfg_wr;
  logic             cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_k_r    <= K_RESET;
      cfg_repl_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_K:    cfg_k_r    <= cfg_pwdata[K_W-1:0];
        REG_REPL: cfg_repl_r <= cfg_pwdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_K:    cfg_prdata = 32'(cfg_k_r);
      REG_REPL: cfg_prdata = cfg_repl_r;
      default:  cfg_prdata = '0;
    endcase
  end

  // Effective k, clamped to one and MAX_K.
  logic [KXW-1:0] k_raw;
  logic [KXW-1:0] k_eff;
  logic [KIW-1:0] k_sel;

  always_comb begin
    k_raw = KXW'(cfg_k_r);
    if (cfg_k_r == '0) begin
      k_eff = KXW'(1);
    end else if (k_raw > KXW'(MAX_K)) begin
      k_eff = KXW'(MAX_K);
    end else begin
      k_eff = k_raw;
    end
    k_sel = KIW'(k_eff - KXW'(1));
  end

  // Input field decode.
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] in_col;
  logic [VAL_W-1:0] in_sim;
  logic [RWW-1:0]   in_row_w;
  logic [RWW-1:0]   in_col_w;
  logic             in_acc;

  assign in_row   = in_tdata[ROW_W-1:0];
  assign in_col   = in_tdata[2*ROW_W-1:ROW_W];
  assign in_sim   = in_tdata[2*ROW_W+VAL_W-1:2*ROW_W];
  assign in_row_w = RWW'(in_row);
  assign in_col_w = RWW'(in_col);

  // Control and captured item.
  logic [1:0]        state_r, state_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [AW-1:0]     addr_r;
  logic              row_ok_r, col_ok_r;
  logic [VAL_W-1:0]  sim_r;

  logic             out_vld_r, out_vld_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;
  logic             out_kept_r, out_kept_nxt;
  logic             out_short_r, out_short_nxt;

  logic             chain_ins, chain_clr;
  logic [VAL_W-1:0] bar_val;
  logic             ram_we;
  logic [VAL_W-1:0] bar_a, bar_b;
  logic             short_row, pass;

  assign in_tready = (state_r == ST_IDLE) && (!out_vld_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign chain_ins = in_acc && (in_tuser == OP_LOAD);
  assign chain_clr = (state_r == ST_BAR);

  // A row is short when fewer than k entries arrived, including the last one.
  assign short_row = SEEN_W'(k_eff) > seen_r;
  assign ram_we    = (state_r == ST_BAR) && row_ok_r && !short_row;
  assign pass      = (row_ok_r && kkt_ge(sim_r, bar_a)) || (col_ok_r && kkt_ge(sim_r, bar_b));

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_val_nxt   = out_val_r;
    out_kept_nxt  = out_kept_r;
    out_short_nxt = out_short_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_LOAD) begin
            if (seen_r != SEEN_MAX) begin
              seen_nxt = seen_r + 1'b1;
            end
            if (in_tlast) begin
              state_nxt = ST_BAR;
            end
          end else begin
            state_nxt = ST_FILTER;
          end
        end
      end
      ST_BAR: begin
        // The output register is known to be empty here: the transfer that led
        // here was only taken with the register free or draining.
        out_vld_nxt   = 1'b1;
        out_kind_nxt  = KIND_BAR;
        out_val_nxt   = short_row ? '0 : bar_val;
        out_kept_nxt  = 1'b0;
        out_short_nxt = short_row;
        seen_nxt      = '0;
        state_nxt     = ST_IDLE;
      end
      ST_FILTER: begin
        out_vld_nxt   = 1'b1;
        out_kind_nxt  = KIND_FILTER;
        out_val_nxt   = pass ? sim_r : cfg_repl_r;
        out_kept_nxt  = pass;
        out_short_nxt = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      seen_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seen_r    <= seen_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_val_r   <= out_val_nxt;
    out_kept_r  <= out_kept_nxt;
    out_short_r <= out_short_nxt;
    if (in_acc) begin
      addr_r   <= in_row_w[AW-1:0];
      row_ok_r <= in_row_w < RWW'(MAX_ROWS);
      col_ok_r <= in_col_w < RWW'(MAX_ROWS);
      sim_r    <= in_sim;
    end
  end

  kkt_chain #(
    .MAX_K(MAX_K),
    .KIW  (KIW)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (chain_clr),
    .ins    (chain_ins),
    .din    (in_sim),
    .sel    (k_sel),
    .bar_val(bar_val)
  );

  kkt_bar_ram #(
    .DEPTH(MAX_ROWS),
    .AW   (AW)
  ) u_bar_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (addr_r),
    .wdata  (bar_val),
    .re     (in_acc),
    .ra_addr(in_row_w[AW-1:0]),
    .rb_addr(in_col_w[AW-1:0]),
    .ra_data(bar_a),
    .rb_data(bar_b)
  );

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {(OUT_TDATA_W-VAL_W-2)'(0), out_short_r, out_kept_r, out_val_r};

  // A row-end or filter state only runs with the output register empty.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_vld_r)
    else $error("result register busy while an item finishes");

  // Row end always returns to idle with the entry count cleared.
  a_bar_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BAR) |=> (state_r == ST_IDLE) && (seen_r == '0))
    else $error("row end did not clear the entry count");

  // A taken row-ending load leads to the bar cycle.
  a_last_to_bar: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == OP_LOAD) && in_tlast) |=> (state_r == ST_BAR))
    else $error("row-ending load did not reach the bar cycle");

  // A filter state delivers a filter result in the following cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILTER) |=> out_vld_r && (out_kind_r == KIND_FILTER))
    else $error("filter produced no result");

endmodule

// ===== dv/kkt_threshold_scoreboard.sv =====
// Scoreboard for the kernel threshold block: row-bar and filter predictor with its result checks.
class kkt_threshold_scoreboard;

  localparam int DEPTH     = kkt_pkg::DEF_MAX_K;
  localparam int ROWS      = kkt_pkg::DEF_MAX_ROWS;
  localparam int PRINT_CAP = 30;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        kept;
    logic        short_row;
  } outcome_t;

  logic [kkt_pkg::K_W-1:0]    k_reg;
  logic [31:0]                repl_reg;
  logic signed [31:0]         top_vals [DEPTH];
  logic [kkt_pkg::SEEN_W-1:0] seen;
  logic [31:0]                bars [ROWS];
  bit                         bar_loaded [ROWS];
  int                         loaded_rows [$];
  outcome_t                   outcomes_due [$];

  int errors;
  int bar_results;
  int short_rows;
  int filter_results;
  int kept_results;

  function new();
    k_reg          = kkt_pkg::K_RESET;
    repl_reg       = '0;
    seen           = '0;
    errors         = 0;
    bar_results    = 0;
    short_rows     = 0;
    filter_results = 0;
    kept_results   = 0;
    foreach (bars[i]) begin
      bars[i]       = '0;
      bar_loaded[i] = 1'b0;
    end
    clear_row();
  endfunction

  function void clear_row();
    foreach (top_vals[i]) top_vals[i] = '0;
    seen = '0;
  endfunction

  function void set_reg(logic idx, logic [31:0] data);
    if (idx == kkt_pkg::REG_K) k_reg = data[kkt_pkg::K_W-1:0];
    else repl_reg = data;
  endfunction

  // Zero acts as one and anything past the list depth acts as the depth.
  function int unsigned k_eff();
    if (k_reg == 0) return 1;
    if (k_reg > DEPTH) return DEPTH;
    return k_reg;
  endfunction

  // Sorted insertion into the descending list; equal values stay ahead of the new one.
  function void insert_top(logic signed [31:0] v);
    int used;
    int pos;
    int i;
    used = (seen < DEPTH) ? int'(seen) : DEPTH;
    pos  = 0;
    while (pos < used && top_vals[pos] >= v) pos++;
    if (pos >= DEPTH) return;
    i = (used < DEPTH) ? used : DEPTH - 1;
    while (i > pos) begin
      top_vals[i] = top_vals[i-1];
      i--;
    end
    top_vals[pos] = v;
  endfunction

  function void note_accepted_item(logic op, logic [9:0] row, logic [9:0] col,
                                   logic [31:0] sim, logic last);
    outcome_t o;
    int unsigned k;
    bit pass;
    if (op == kkt_pkg::OP_LOAD) begin
      insert_top($signed(sim));
      if (seen != kkt_pkg::SEEN_MAX) seen++;
      if (!last) return;
      k           = k_eff();
      o.kind      = kkt_pkg::KIND_BAR;
      o.kept      = 1'b0;
      if (seen >= k) begin
        o.value     = top_vals[k-1];
        o.short_row = 1'b0;
        bars[row]   = top_vals[k-1];
        if (!bar_loaded[row]) loaded_rows.push_back(row);
        bar_loaded[row] = 1'b1;
      end else begin
        o.value     = '0;
        o.short_row = 1'b1;
      end
      clear_row();
    end else begin
      pass = ($signed(sim) >= $signed(bars[row])) || ($signed(sim) >= $signed(bars[col]));
      o.kind      = kkt_pkg::KIND_FILTER;
      o.value     = pass ? sim : repl_reg;
      o.kept      = pass;
      o.short_row = 1'b0;
    end
    outcomes_due.push_back(o);
  endfunction

  function int pending_count();
    return outcomes_due.size();
  endfunction

  function int random_loaded_row();
    return loaded_rows[$urandom_range(loaded_rows.size() - 1)];
  endfunction

  function logic [31:0] bar_of(int row);
    return bars[row];
  endfunction

  task report_mismatch(string msg);
    if (errors < PRINT_CAP) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_output(logic kind, logic [kkt_pkg::OUT_TDATA_W-1:0] tdata);
    outcome_t got;
    outcome_t want;
    got.kind      = kind;
    got.value     = tdata[31:0];
    got.kept      = tdata[32];
    got.short_row = tdata[33];
    if (outcomes_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0b value %h", kind, tdata[31:0]));
      return;
    end
    want = outcomes_due.pop_front();
    if (got.kind != want.kind)
      report_mismatch($sformatf("kind %0b, wanted %0b", got.kind, want.kind));
    if (got.value != want.value)
      report_mismatch($sformatf("value %h, wanted %h (kind %0b)",
                                got.value, want.value, want.kind));
    if (got.kept != want.kept)
      report_mismatch($sformatf("kept %0b, wanted %0b", got.kept, want.kept));
    if (got.short_row != want.short_row)
      report_mismatch($sformatf("short_row %0b, wanted %0b", got.short_row, want.short_row));
    if (want.kind == kkt_pkg::KIND_BAR) begin
      bar_results++;
      if (want.short_row) short_rows++;
    end else begin
      filter_results++;
      if (want.kept) kept_results++;
    end
  endtask

  task report_leftovers();
    foreach (outcomes_due[i])
      report_mismatch($sformatf("result never arrived: kind %0b value %h",
                                outcomes_due[i].kind, outcomes_due[i].value));
  endtask

endclass

// ===== dv/tb_knn_kernel_threshold.sv =====
// Self-checking testbench for the k-nearest-neighbor kernel threshold block.
module tb_knn_kernel_threshold;
  import kkt_pkg::*;

  // The limit leaves a wide margin over the slowest correct run for stalls on
  // both channels.
  localparam int LIMIT_CYCLES = 400000;
  // A row-ending load or a filter is done once its result is out, so this wait
  // after the last result is enough for the block to settle.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 40;
  localparam int LONG_ROW      = 2049;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [31:0]            cfg_pwdata;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  kkt_threshold_scoreboard sb;

  // While set, neither the sender nor the receiver inserts idle cycles.
  bit steady;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned loads_sent;
  int unsigned filters_sent;

  knn_kernel_threshold u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver drops ready at random, with odds of about 15 in a hundred. Its ready changes
  // only at falling edges, so it is stable whenever the monitor samples it.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= steady || ($urandom_range(99) >= 15);
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tuser, out_tdata);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycles, sb.pending_count());
    $display("== FAIL ==");
    $finish;
  end

  // One input transfer. The task is entered just after a rising edge; data
  // changes at a falling edge, the next one unless idle cycles with tvalid low
  // come first, and the transfer is complete at the first rising edge that sees
  // ready. tvalid stays high between back-to-back transfers.
  task automatic send_item(logic op, logic [9:0] row, logic [9:0] col,
                           logic [31:0] sim, logic last);
    int unsigned gap;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 15) begin
      gap = $urandom_range(4, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {4'b0, sim, col, row};
    do @(posedge clk); while (!in_tready);
    sb.note_accepted_item(op, row, col, sim, last);
    items_sent++;
    if (op == OP_LOAD) loads_sent++;
    else filters_sent++;
  endtask

  // Stops the input stream and waits until every predicted result has come
  // out. A half-loaded row produces nothing, so the task then waits out the
  // settle time as well before the block can be taken as idle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(logic idx, logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Similarities lean toward the signed extremes and a small pool of values,
  // so that duplicates and ties are common.
  function automatic logic [31:0] pick_similarity();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return ($urandom_range(7) << 16) - 32'h0004_0000;
      4: return $urandom_range(1) ? 32'h0000_0000 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // A filter names only rows whose bar has been written. Its value often sits
  // on or right next to one of the two bars, to exercise the inclusive compare.
  task automatic send_random_filter();
    int          r;
    int          c;
    logic [31:0] sim;
    r = sb.random_loaded_row();
    c = sb.random_loaded_row();
    case ($urandom_range(6))
      0: sim = sb.bar_of(r);
      1: sim = sb.bar_of(c);
      2: sim = sb.bar_of(r) - 1;
      3: sim = sb.bar_of(c) - 1;
      4: sim = sb.bar_of(r) + 1;
      default: sim = pick_similarity();
    endcase
    send_item(OP_FILTER, r[9:0], c[9:0], sim, 1'($urandom_range(1)));
  endtask

  // One well-formed row, with filters mixed in unless they are turned off.
  // Most rows are at least k long; some are short. Now and then an entry,
  // the row-ending one too, carries a stray row index; the block must ignore
  // the index of every entry but the row-ending one.
  task automatic send_random_row(int unsigned len, bit with_filters = 1'b1);
    logic [9:0]  row;
    int unsigned i;
    row = 10'($urandom_range(1023));
    for (i = 0; i < len; i++) begin
      if (with_filters && sb.loaded_rows.size() != 0 && $urandom_range(99) < 35)
        send_random_filter();
      send_item(OP_LOAD, ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : row,
                10'($urandom_range(1023)), pick_similarity(), i == len - 1);
    end
  endtask

  function automatic int unsigned pick_row_length();
    int unsigned keff;
    keff = sb.k_eff();
    if (keff > 1 && $urandom_range(99) < 15) return $urandom_range(keff - 1, 1);
    return $urandom_range(keff + 6, keff);
  endfunction

  initial begin
    logic [4:0]  phase_k [6];
    logic [31:0] phase_repl [6];
    int unsigned start;
    int          p;

    sb           = new();
    steady       = 1'b0;
    items_sent   = 0;
    loads_sent   = 0;
    filters_sent = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_LOAD;
    in_tlast     = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with k at its reset value of two. Row 0 holds both
    // extremes and a duplicated maximum, so its bar is the maximum itself.
    send_item(OP_LOAD, 10'd0, 10'd1023, 32'h7fff_ffff, 1'b0);
    send_item(OP_LOAD, 10'd0, 10'd0, 32'h8000_0000, 1'b0);
    send_item(OP_LOAD, 10'd0, 10'h155, 32'h7fff_ffff, 1'b0);
    send_item(OP_LOAD, 10'd0, 10'h2aa, 32'h0005_0000, 1'b1);
    // A one-entry row is short and leaves its bar alone; the next row
    // at the same index sets the bar to the most negative value.
    send_item(OP_LOAD, 10'd1023, 10'd0, 32'h0001_0000, 1'b1);
    send_item(OP_LOAD, 10'd1023, 10'd0, 32'h8000_0000, 1'b0);
    send_item(OP_LOAD, 10'd1023, 10'd0, 32'h8000_0000, 1'b1);
    // Filters: equal to a bar passes, one below both bars is replaced.
    send_item(OP_FILTER, 10'd0, 10'd1023, 32'h7fff_ffff, 1'b0);
    send_item(OP_FILTER, 10'd1023, 10'd0, 32'h8000_0000, 1'b1);
    send_item(OP_FILTER, 10'd0, 10'd0, 32'h7fff_fffe, 1'b0);
    // A row interrupted by a filter, and then by a change of k while the
    // block is otherwise idle. A k of zero acts as one.
    send_item(OP_LOAD, 10'd5, 10'd0, 32'hffff_0000, 1'b0);
    send_item(OP_FILTER, 10'd0, 10'd0, 32'h0000_0000, 1'b1);
    send_item(OP_LOAD, 10'd5, 10'd0, 32'h0003_8000, 1'b0);
    drain();
    cfg_write(REG_K, 32'd0);
    cfg_write(REG_REPL, 32'h8000_0000);
    send_item(OP_LOAD, 10'd5, 10'd0, 32'h0000_0001, 1'b1);
    send_item(OP_FILTER, 10'd5, 10'd5, 32'h0003_7fff, 1'b0);
    send_item(OP_FILTER, 10'd5, 10'd0, 32'h0003_8000, 1'b0);
    // A k above the list depth acts as the depth, so three entries are short.
    drain();
    cfg_write(REG_K, 32'd31);
    cfg_write(REG_REPL, 32'h7fff_ffff);
    send_item(OP_LOAD, 10'd7, 10'd0, 32'h0000_0010, 1'b0);
    send_item(OP_LOAD, 10'd7, 10'd0, 32'h0000_0020, 1'b0);
    send_item(OP_LOAD, 10'd7, 10'd0, 32'h0000_0030, 1'b1);
    send_item(OP_FILTER, 10'd0, 10'd5, 32'hffff_ffff, 1'b0);

    // Random part in phases, each under its own register setting.
    phase_k    = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'($urandom_range(31))};
    phase_repl = '{32'h8000_0000, 32'h7fff_ffff, $urandom, 32'h0, $urandom, $urandom};
    for (p = 0; p < 6; p++) begin
      drain();
      cfg_write(REG_K, {27'b0, phase_k[p]});
      cfg_write(REG_REPL, phase_repl[p]);
      // The third phase runs with no idle cycles on either side.
      steady = (p == 2);
      // One row long enough to saturate the entry counter. It carries loads
      // only, which keeps the whole run near its item budget.
      if (p == 4) send_random_row(LONG_ROW, 1'b0);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_row(pick_row_length());
    end
    steady = 1'b0;

    drain();
    sb.report_leftovers();
    $display("Ran %0d transfers (%0d loads, %0d filters) through %0d register settings.",
             items_sent, loads_sent, filters_sent, 9);
    $display("Checked %0d bar results (%0d short rows) and %0d filter results (%0d kept).",
             sb.bar_results, sb.short_rows, sb.filter_results, sb.kept_results);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches.", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kkt_pkg.sv
sv/kkt_cell.sv
sv/kkt_chain.sv
sv/kkt_bar_ram.sv
sv/knn_kernel_threshold.sv
dv/kkt_threshold_scoreboard.sv
dv/tb_knn_kernel_threshold.sv
